@@ hdl/ft_pkg.sv @@
// Shared types and constants of the flow totalizer.
// Used by ft_ctrl, ft_dpath, flow_totalizer_top, ft_tick_checker and testbench; depends on nothing.
package ft_pkg;

    // field widths
    localparam int NOW_W      = 32;
    localparam int VAL_W      = 32;
    localparam int TOT_W      = 48;
    localparam int SCALE_W    = 32;
    localparam int SD_W       = 47;
    localparam int MODE_W     = 3;
    localparam int QUAL_W     = 2;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // accumulate modes
    localparam logic [MODE_W-1:0] MODE_DELTA     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ABS_DELTA = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RATE_SEC  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RATE_MIN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RATE_HOUR = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RETAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAVE_DL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STAT_W-1:0] STAT_RESET       = 3'd1;
    localparam logic [STAT_W-1:0] STAT_SAVED       = 3'd2;
    localparam logic [STAT_W-1:0] STAT_RESET_SAVED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_SAVE_FAIL   = 3'd4;
    localparam logic [STAT_W-1:0] STAT_MISSING     = 3'd5;

    // quality codes
    localparam logic [QUAL_W-1:0] QUAL_UNINIT = 2'd0;
    localparam logic [QUAL_W-1:0] QUAL_GOOD   = 2'd1;
    localparam logic [QUAL_W-1:0] QUAL_FAULT  = 2'd3;

    // register defaults
    localparam logic [SCALE_W-1:0] SCALE_ONE   = 32'd65536;
    localparam logic [SD_W-1:0]    SD_DFLT     = 47'd65536;
    localparam logic [NOW_W-1:0]   PERIOD_DFLT = 32'd60000;

    // divisor unit_ms * 2^16 = odd * 2^shift
    localparam int REM_W = 15;
    localparam int SH_W  = 5;
    localparam logic [REM_W-1:0] ODD_ONE  = 15'd1;
    localparam logic [REM_W-1:0] ODD_SEC  = 15'd125;
    localparam logic [REM_W-1:0] ODD_MIN  = 15'd1875;
    localparam logic [REM_W-1:0] ODD_HOUR = 15'd28125;
    localparam logic [SH_W-1:0]  SH_DELTA = 5'd16;
    localparam logic [SH_W-1:0]  SH_SEC   = 5'd19;
    localparam logic [SH_W-1:0]  SH_MIN   = 5'd21;
    localparam logic [SH_W-1:0]  SH_HOUR  = 5'd23;

    // arithmetic widths
    localparam int MAG_W     = 33;
    localparam int PROD_W    = 64;
    localparam int NUM_W     = 96;
    localparam int DVD_W     = 80;
    localparam int DIG_BITS  = 8;
    localparam int DIV_STEPS = DVD_W / DIG_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
    localparam int INC_W     = 49;
    localparam logic [INC_W-1:0] INC_CAP = 49'h1000000000000;
    localparam logic [TOT_W-1:0] TOT_MAX = 48'h7FFFFFFFFFFF;
    localparam logic [TOT_W-1:0] TOT_MIN = 48'h800000000000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_PP_LO,
        ST_PP_HI,
        ST_LOAD,
        ST_DIV,
        ST_ROUND,
        ST_ADD,
        ST_SAVE,
        ST_OUT
    } t_ft_state;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic mul;
        logic pp_lo;
        logic pp_hi;
        logic load_div;
        logic div_step;
        logic round;
        logic add;
        logic save;
        logic commit;
    } t_ft_cmd;

    typedef struct packed {
        logic missing;
        logic delta_mode;
    } t_ft_sts;

endpackage

@@ hdl/ft_ctrl.sv @@
// Sequencer of the flow totalizer: one item at a time through the datapath.
// Depends on ft_pkg.
module ft_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    input  ft_pkg::t_ft_sts i_sts,
    output logic            o_in_ready,
    output ft_pkg::t_ft_cmd o_cmd
);

    ft_pkg::t_ft_state             r_state, n_state;
    logic [ft_pkg::CNT_W-1:0]      r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ft_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ft_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ft_pkg::ST_PREP;
                end
            end
            ft_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_sts.missing ? ft_pkg::ST_OUT : ft_pkg::ST_MUL;
            end
            ft_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ft_pkg::ST_PP_LO;
            end
            ft_pkg::ST_PP_LO: begin
                o_cmd.pp_lo = 1'b1;
                n_state     = ft_pkg::ST_PP_HI;
            end
            ft_pkg::ST_PP_HI: begin
                o_cmd.pp_hi = 1'b1;
                n_state     = ft_pkg::ST_LOAD;
            end
            ft_pkg::ST_LOAD: begin
                o_cmd.load_div = 1'b1;
                n_cnt          = '0;
                // delta modes divide by a power of two only
                n_state = i_sts.delta_mode ? ft_pkg::ST_ROUND : ft_pkg::ST_DIV;
            end
            ft_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == ft_pkg::CNT_LAST) begin
                    n_state = ft_pkg::ST_ROUND;
                end
            end
            ft_pkg::ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = ft_pkg::ST_ADD;
            end
            ft_pkg::ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ft_pkg::ST_SAVE;
            end
            ft_pkg::ST_SAVE: begin
                o_cmd.save = 1'b1;
                n_state    = ft_pkg::ST_OUT;
            end
            ft_pkg::ST_OUT: begin
                if (i_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ft_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ft_pkg::ST_IDLE;
            end
        endcase
    end

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_out_free)
        else $error("commit while output register is occupied");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ft_pkg::ST_DIV) |-> (r_cnt <= ft_pkg::CNT_LAST))
        else $error("divider step count out of range");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> (r_state == ft_pkg::ST_PREP))
        else $error("accepted item did not enter preparation");

endmodule

@@ hdl/ft_dpath.sv @@
// Datapath of the flow totalizer: config registers, state, multiply,
// constant divide with rounding, saturating add and save decision. Depends on ft_pkg.
module ft_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ft_pkg::t_ft_cmd               i_cmd,
    output ft_pkg::t_ft_sts               o_sts,
    input  logic                          i_cfg_we,
    input  logic [ft_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ft_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ft_pkg::NOW_W-1:0]      i_now_ms,
    input  logic                          i_sample_present,
    input  logic [ft_pkg::VAL_W-1:0]      i_sample_value,
    input  logic [ft_pkg::QUAL_W-1:0]     i_sample_quality,
    input  logic                          i_reset_level,
    input  logic                          i_store_ready,
    output logic [ft_pkg::TOT_W-1:0]      o_total_value,
    output logic [ft_pkg::QUAL_W-1:0]     o_out_quality,
    output logic [ft_pkg::STAT_W-1:0]     o_status_code,
    output logic                          o_save_request
);

    // configuration
    logic [ft_pkg::MODE_W-1:0]  r_cfg_mode;
    logic [ft_pkg::SCALE_W-1:0] r_cfg_scale;
    logic [ft_pkg::TOT_W-1:0]   r_cfg_init;
    logic                       r_cfg_retain;
    logic [ft_pkg::SD_W-1:0]    r_cfg_sd;
    logic [ft_pkg::NOW_W-1:0]   r_cfg_period;

    // captured item
    logic [ft_pkg::NOW_W-1:0]   r_now;
    logic                       r_present;
    logic [ft_pkg::VAL_W-1:0]   r_sample;
    logic [ft_pkg::QUAL_W-1:0]  r_quality;
    logic                       r_rst;
    logic                       r_ready;

    // persistent state
    logic [ft_pkg::TOT_W-1:0]   r_total;
    logic [ft_pkg::TOT_W-1:0]   r_saved_total;
    logic [ft_pkg::VAL_W-1:0]   r_prev_sample;
    logic [ft_pkg::NOW_W-1:0]   r_last_tick;
    logic [ft_pkg::NOW_W-1:0]   r_last_save;
    logic                       r_prev_rst;
    logic                       r_baseline;
    logic                       r_started;

    // arithmetic pipeline
    logic [ft_pkg::MAG_W-1:0]   r_mag_a;
    logic [ft_pkg::SCALE_W-1:0] r_mag_b;
    logic [ft_pkg::NOW_W-1:0]   r_mult_e;
    logic                       r_neg;
    logic [ft_pkg::PROD_W-1:0]  r_prod;
    logic [ft_pkg::PROD_W-1:0]  r_pp_lo;
    logic [ft_pkg::PROD_W-1:0]  r_pp_hi;
    logic [ft_pkg::DVD_W-1:0]   r_dvd;
    logic [ft_pkg::REM_W-1:0]   r_rem;
    logic                       r_rbit;
    logic [ft_pkg::INC_W-1:0]   r_inc;
    logic [ft_pkg::STAT_W-1:0]  r_status;
    logic                       r_persist;

    logic                       w_edge;
    logic                       w_delta;
    logic [ft_pkg::VAL_W-1:0]   w_prev_eff;
    logic [ft_pkg::NOW_W-1:0]   w_tick_eff;
    logic [ft_pkg::SCALE_W-1:0] w_scale_eff;
    logic [ft_pkg::SCALE_W-1:0] w_scale_mag;
    logic [ft_pkg::MAG_W-1:0]   w_d;
    logic [ft_pkg::MAG_W-1:0]   w_d_neg;
    logic [ft_pkg::MAG_W-1:0]   w_d_mag;
    logic [ft_pkg::VAL_W-1:0]   w_val_mag;
    logic [ft_pkg::NOW_W-1:0]   w_el;
    logic [ft_pkg::PROD_W:0]    w_prod_full;
    logic [ft_pkg::NUM_W-1:0]   w_num;
    logic [ft_pkg::NUM_W-1:0]   w_num_sh;
    logic                       w_num_rbit;
    logic [ft_pkg::REM_W-1:0]   w_odd;
    logic [ft_pkg::DVD_W-1:0]   w_dvd_next;
    logic [ft_pkg::REM_W-1:0]   w_rem_next;
    logic [ft_pkg::REM_W:0]     w_twice_rem;
    logic                       w_round_up;
    logic [ft_pkg::DVD_W-1:0]   w_q_r;
    logic [ft_pkg::TOT_W+1:0]   w_sum;
    logic [ft_pkg::TOT_W-1:0]   w_sum_sat;
    logic [ft_pkg::TOT_W:0]     w_diff;
    logic [ft_pkg::TOT_W:0]     w_diff_mag;
    logic [ft_pkg::SD_W-1:0]    w_sd_eff;
    logic [ft_pkg::NOW_W-1:0]   w_period_eff;
    logic                       w_by_delta;
    logic                       w_by_time;
    logic                       w_persist;

    assign w_edge  = !r_prev_rst && r_rst;
    assign w_delta = (r_cfg_mode == ft_pkg::MODE_DELTA) ||
                     (r_cfg_mode == ft_pkg::MODE_ABS_DELTA);

    assign o_sts.missing    = !r_present;
    assign o_sts.delta_mode = w_delta;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode   <= ft_pkg::MODE_DELTA;
            r_cfg_scale  <= ft_pkg::SCALE_ONE;
            r_cfg_init   <= '0;
            r_cfg_retain <= 1'b0;
            r_cfg_sd     <= ft_pkg::SD_DFLT;
            r_cfg_period <= ft_pkg::PERIOD_DFLT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ft_pkg::REG_MODE:    r_cfg_mode   <= i_cfg_data[ft_pkg::MODE_W-1:0];
                ft_pkg::REG_SCALE:   r_cfg_scale  <= i_cfg_data[ft_pkg::SCALE_W-1:0];
                ft_pkg::REG_INIT:    r_cfg_init   <= i_cfg_data[ft_pkg::TOT_W-1:0];
                ft_pkg::REG_RETAIN:  r_cfg_retain <= i_cfg_data[0];
                ft_pkg::REG_SAVE_DL: r_cfg_sd     <= i_cfg_data[ft_pkg::SD_W-1:0];
                ft_pkg::REG_PERIOD:  r_cfg_period <= i_cfg_data[ft_pkg::NOW_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- operand preparation ----------------
    always_comb begin
        w_prev_eff  = r_baseline ? r_prev_sample : r_sample;
        w_tick_eff  = (r_started && r_baseline) ? r_last_tick : r_now;
        w_scale_eff = (r_cfg_scale == '0) ? ft_pkg::SCALE_ONE : r_cfg_scale;
        w_scale_mag = w_scale_eff[ft_pkg::SCALE_W-1] ? (~w_scale_eff + 1'b1) : w_scale_eff;
        w_d         = {r_sample[ft_pkg::VAL_W-1], r_sample} -
                      {w_prev_eff[ft_pkg::VAL_W-1], w_prev_eff};
        w_d_neg     = ~w_d + 1'b1;
        if (r_cfg_mode == ft_pkg::MODE_ABS_DELTA) begin
            w_d_mag = w_d[ft_pkg::MAG_W-1] ? w_d_neg : w_d;
        end else begin
            w_d_mag = w_d[ft_pkg::MAG_W-1] ? '0 : w_d;
        end
        w_val_mag = r_sample[ft_pkg::VAL_W-1] ? (~r_sample + 1'b1) : r_sample;
        w_el      = (r_now >= w_tick_eff) ? (r_now - w_tick_eff) : '0;
    end

    // ---------------- divisor selection ----------------
    always_comb begin
        w_num = {r_pp_hi, 32'b0} + {32'b0, r_pp_lo};
        if (w_delta) begin
            w_num_sh   = w_num >> ft_pkg::SH_DELTA;
            w_num_rbit = w_num[ft_pkg::SH_DELTA - 1'b1];
            w_odd      = ft_pkg::ODD_ONE;
        end else if (r_cfg_mode == ft_pkg::MODE_RATE_SEC) begin
            w_num_sh   = w_num >> ft_pkg::SH_SEC;
            w_num_rbit = w_num[ft_pkg::SH_SEC - 1'b1];
            w_odd      = ft_pkg::ODD_SEC;
        end else if (r_cfg_mode == ft_pkg::MODE_RATE_HOUR) begin
            w_num_sh   = w_num >> ft_pkg::SH_HOUR;
            w_num_rbit = w_num[ft_pkg::SH_HOUR - 1'b1];
            w_odd      = ft_pkg::ODD_HOUR;
        end else begin
            // per minute, also for the unused mode codes
            w_num_sh   = w_num >> ft_pkg::SH_MIN;
            w_num_rbit = w_num[ft_pkg::SH_MIN - 1'b1];
            w_odd      = ft_pkg::ODD_MIN;
        end
    end

    // ---------------- divider digit: DIG_BITS quotient bits per cycle ----------------
    always_comb begin
        logic [ft_pkg::REM_W:0]   rem_t;
        logic [ft_pkg::REM_W-1:0] rem_v;
        logic [ft_pkg::DVD_W-1:0] dvd_v;
        rem_v = r_rem;
        dvd_v = r_dvd;
        for (int i = 0; i < ft_pkg::DIG_BITS; i++) begin
            rem_t = {rem_v, dvd_v[ft_pkg::DVD_W-1]};
            dvd_v = {dvd_v[ft_pkg::DVD_W-2:0], 1'b0};
            if (rem_t >= {1'b0, w_odd}) begin
                rem_t    = rem_t - {1'b0, w_odd};
                dvd_v[0] = 1'b1;
            end
            rem_v = rem_t[ft_pkg::REM_W-1:0];
        end
        w_rem_next = rem_v;
        w_dvd_next = dvd_v;
    end

    // round half away from zero: remainder is rem * 2^shift + low bits
    always_comb begin
        w_twice_rem = {r_rem, 1'b0};
        w_round_up  = (w_twice_rem >= {1'b0, w_odd}) ||
                      (((w_twice_rem + 1'b1) == {1'b0, w_odd}) && r_rbit);
        w_q_r       = r_dvd + {{(ft_pkg::DVD_W-1){1'b0}}, w_round_up};
    end

    // ---------------- saturating accumulate ----------------
    always_comb begin
        if (r_neg) begin
            w_sum = {{2{r_total[ft_pkg::TOT_W-1]}}, r_total} - {1'b0, r_inc};
        end else begin
            w_sum = {{2{r_total[ft_pkg::TOT_W-1]}}, r_total} + {1'b0, r_inc};
        end
        if (w_sum[ft_pkg::TOT_W+1:ft_pkg::TOT_W-1] == 3'b000 ||
            w_sum[ft_pkg::TOT_W+1:ft_pkg::TOT_W-1] == 3'b111) begin
            w_sum_sat = w_sum[ft_pkg::TOT_W-1:0];
        end else begin
            w_sum_sat = w_sum[ft_pkg::TOT_W+1] ? ft_pkg::TOT_MIN : ft_pkg::TOT_MAX;
        end
    end

    // ---------------- save decision ----------------
    always_comb begin
        w_diff       = {r_total[ft_pkg::TOT_W-1], r_total} -
                       {r_saved_total[ft_pkg::TOT_W-1], r_saved_total};
        w_diff_mag   = w_diff[ft_pkg::TOT_W] ? (~w_diff + 1'b1) : w_diff;
        w_sd_eff     = (r_cfg_sd == '0) ? ft_pkg::SD_DFLT : r_cfg_sd;
        w_period_eff = (r_cfg_period == '0) ? ft_pkg::PERIOD_DFLT : r_cfg_period;
        w_by_delta   = w_diff_mag >= {2'b00, w_sd_eff};
        w_by_time    = (r_now >= r_last_save) && ((r_now - r_last_save) >= w_period_eff);
        w_persist    = r_cfg_retain && (w_edge || w_by_delta || w_by_time);
    end

    // ---------------- control state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_rst <= 1'b0;
            r_baseline <= 1'b0;
            r_started  <= 1'b0;
        end else begin
            if (i_cmd.prep && !r_started) begin
                r_started <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_prev_rst <= r_rst;
                if (r_present) begin
                    r_baseline <= 1'b1;
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    assign w_prod_full = {32'b0, r_mag_a} * {33'b0, r_mag_b};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_now     <= i_now_ms;
            r_present <= i_sample_present;
            r_sample  <= i_sample_value;
            r_quality <= i_sample_quality;
            r_rst     <= i_reset_level;
            r_ready   <= i_store_ready;
        end
        if (i_cmd.prep) begin
            if (!r_started) begin
                r_total       <= r_cfg_init;
                r_saved_total <= r_cfg_init;
                r_last_save   <= r_now;
                r_last_tick   <= r_now;
            end
            if (w_delta) begin
                r_mag_a  <= w_d_mag;
                r_mult_e <= {{(ft_pkg::NOW_W-1){1'b0}}, 1'b1};
                r_neg    <= w_scale_eff[ft_pkg::SCALE_W-1];
            end else begin
                r_mag_a  <= {1'b0, w_val_mag};
                r_mult_e <= w_el;
                r_neg    <= r_sample[ft_pkg::VAL_W-1] ^ w_scale_eff[ft_pkg::SCALE_W-1];
            end
            r_mag_b <= w_scale_mag;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod_full[ft_pkg::PROD_W-1:0];
        end
        if (i_cmd.pp_lo) begin
            r_pp_lo <= {32'b0, r_prod[31:0]} * {32'b0, r_mult_e};
        end
        if (i_cmd.pp_hi) begin
            r_pp_hi <= {32'b0, r_prod[63:32]} * {32'b0, r_mult_e};
        end
        if (i_cmd.load_div) begin
            r_dvd  <= w_num_sh[ft_pkg::DVD_W-1:0];
            r_rem  <= '0;
            r_rbit <= w_num_rbit;
        end
        if (i_cmd.div_step) begin
            r_dvd <= w_dvd_next;
            r_rem <= w_rem_next;
        end
        if (i_cmd.round) begin
            r_inc <= (w_q_r > {{(ft_pkg::DVD_W-ft_pkg::INC_W){1'b0}}, ft_pkg::INC_CAP}) ?
                     ft_pkg::INC_CAP : w_q_r[ft_pkg::INC_W-1:0];
        end
        if (i_cmd.add) begin
            r_total <= w_edge ? r_cfg_init : w_sum_sat;
        end
        if (i_cmd.save) begin
            r_persist <= w_persist;
            if (w_persist) begin
                if (r_ready) begin
                    r_status      <= w_edge ? ft_pkg::STAT_RESET_SAVED : ft_pkg::STAT_SAVED;
                    r_saved_total <= r_total;
                    r_last_save   <= r_now;
                end else begin
                    r_status <= ft_pkg::STAT_SAVE_FAIL;
                end
            end else begin
                r_status <= w_edge ? ft_pkg::STAT_RESET : ft_pkg::STAT_OK;
            end
        end
        if (i_cmd.commit && r_present) begin
            r_prev_sample <= r_sample;
            r_last_tick   <= r_now;
        end
    end

    // ---------------- result fields ----------------
    always_comb begin
        o_total_value = r_total;
        if (!r_present) begin
            o_out_quality  = ft_pkg::QUAL_FAULT;
            o_status_code  = ft_pkg::STAT_MISSING;
            o_save_request = 1'b0;
        end else begin
            o_out_quality  = (r_quality == ft_pkg::QUAL_UNINIT) ? ft_pkg::QUAL_GOOD : r_quality;
            o_status_code  = r_status;
            o_save_request = r_persist;
        end
    end

    a_inc_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add |-> (r_inc <= ft_pkg::INC_CAP))
        else $error("increment above its clamp");

endmodule

@@ hdl/flow_totalizer_top.sv @@
// Top level of the flow totalizer: stream ports, output register, and the
// controller and datapath. Depends on ft_pkg, ft_ctrl and ft_dpath.
//
// Use: every tick is one item on the s-side stream; each item gives exactly
// one result item on the m-side stream, in order. The cfg channel writes one
// register (index 0..5) per handshake and is always ready; write it only
// while no item is in flight. Indexes 6 and 7 are ignored.
//
// Timing: one item is worked at a time. After acceptance the result is
// registered on o_m_* and o_s_tready rises in that same cycle. In the rate
// modes an item passes preparation, three multiply stages (scale, then elapsed
// time in two halves), the divider with 8 quotient bits per cycle, rounding,
// add and save; the delta modes skip the divider and a missing sample goes
// straight from preparation to the output register.
//
// Reset (i_rst_n low, synchronous): registers return to their defaults, the
// output register empties and the next item is treated as the first one.
// Stall: a result waits in the output register while o_s_tready accepts the
// next item; that item's result is held back until the register is taken.
module flow_totalizer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [31:0] now_ms, [63:32] sample_value, [64] reset_level, [65] store_ready
    input  logic [71:0]                   i_s_tdata,
    // [0] sample_present, [2:1] sample_quality
    input  logic [2:0]                    i_s_tuser,
    // result items
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [47:0] total_value, [48] save_request
    output logic [55:0]                   o_m_tdata,
    // [1:0] out_quality, [4:2] status_code
    output logic [4:0]                    o_m_tuser,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ft_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ft_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ft_pkg::t_ft_cmd                w_cmd;
    ft_pkg::t_ft_sts                w_sts;
    logic                           w_out_free;
    logic [ft_pkg::TOT_W-1:0]       w_total_value;
    logic [ft_pkg::QUAL_W-1:0]      w_out_quality;
    logic [ft_pkg::STAT_W-1:0]      w_status_code;
    logic                           w_save_request;

    logic                           r_m_tvalid;
    logic [55:0]                    r_m_tdata;
    logic [4:0]                     r_m_tuser;

    assign o_cfg_ready = 1'b1;

    // output slot is free when empty or being drained this cycle
    assign w_out_free = !r_m_tvalid || i_m_tready;

    ft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_in_ready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    ft_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_now_ms         (i_s_tdata[31:0]),
        .i_sample_present (i_s_tuser[0]),
        .i_sample_value   (i_s_tdata[63:32]),
        .i_sample_quality (i_s_tuser[2:1]),
        .i_reset_level    (i_s_tdata[64]),
        .i_store_ready    (i_s_tdata[65]),
        .o_total_value    (w_total_value),
        .o_out_quality    (w_out_quality),
        .o_status_code    (w_status_code),
        .o_save_request   (w_save_request)
    );

    // output register: valid is control, data is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_cmd.commit) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.commit) begin
            r_m_tdata <= {7'b0, w_save_request, w_total_value};
            r_m_tuser <= {w_status_code, w_out_quality};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_m_tvalid)
        else $error("committed result not presented");

endmodule

@@ sim/ft_tick_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for flow_totalizer_top: follows register writes, predicts the result of every
// accepted tick and compares it with the result stream. Depends on ft_pkg only.
module ft_tick_checker
    import ft_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [71:0]           i_s_tdata,
    input  logic [2:0]            i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [55:0]           i_m_tdata,
    input  logic [4:0]            i_m_tuser,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [63:0] MS_PER_SEC  = 64'd1000;
    localparam logic [63:0] MS_PER_MIN  = 64'd60000;
    localparam logic [63:0] MS_PER_HOUR = 64'd3600000;
    localparam longint      TOTAL_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      TOTAL_BOTTOM = -TOTAL_TOP - 64'sd1;

    typedef struct packed {
        logic [TOT_W-1:0]  total;
        logic              save_req;
        logic [QUAL_W-1:0] qual;
        logic [STAT_W-1:0] status;
    } t_tick_result;

    t_tick_result expected_q[$];

    // register copies
    logic [MODE_W-1:0]  cfg_mode;
    logic [SCALE_W-1:0] cfg_scale;
    logic [TOT_W-1:0]   cfg_init;
    logic               cfg_retain;
    logic [SD_W-1:0]    cfg_save_delta;
    logic [NOW_W-1:0]   cfg_period;

    // integrator state
    longint             total_acc;
    longint             saved_total;
    logic [VAL_W-1:0]   prev_sample;
    logic [NOW_W-1:0]   tick_ms;
    logic [NOW_W-1:0]   save_ms;
    logic               prev_rst;
    logic               have_baseline;
    logic               started;

    int                 fails = 0;
    int                 results_seen = 0;

    // round(num / div), ties away from zero, magnitude capped at 2^48
    function automatic logic [INC_W-1:0] round_div(input logic [127:0] num,
                                                   input logic [63:0] div);
        logic [127:0] quo;
        logic [127:0] rem;
        quo = num / div;
        rem = num % div;
        if (quo <= INC_CAP && (rem << 1) >= div) quo = quo + 1;
        if (quo > INC_CAP) quo = INC_CAP;
        return quo[INC_W-1:0];
    endfunction

    function automatic longint clamp_add(input longint base, input logic [INC_W-1:0] mag,
                                         input logic neg);
        longint step;
        longint sum;
        step = {15'd0, mag};
        sum  = neg ? base - step : base + step;
        if (sum > TOTAL_TOP) sum = TOTAL_TOP;
        if (sum < TOTAL_BOTTOM) sum = TOTAL_BOTTOM;
        return sum;
    endfunction

    // one tick through the totalizer; queues the result it must produce
    task automatic integrate_tick(input logic [NOW_W-1:0] now, input logic present,
                                  input logic [VAL_W-1:0] sample, input logic [QUAL_W-1:0] qual,
                                  input logic rst_lvl, input logic ready);
        t_tick_result     res;
        logic             rise;
        logic             persist;
        logic             store_ok;
        logic             by_delta;
        logic             by_time;
        longint           init_v;
        longint           scale_v;
        longint           val_v;
        longint           prev_v;
        longint           diff;
        longint           gap;
        longint           sd;
        logic [63:0]      smag;
        logic [63:0]      vmag;
        logic [63:0]      dmag;
        logic [63:0]      unit_ms;
        logic [127:0]     num;
        logic [INC_W-1:0] inc;
        logic [NOW_W-1:0] elapsed;
        logic [NOW_W-1:0] period;

        rise   = !prev_rst && rst_lvl;
        init_v = $signed(cfg_init);
        if (!started) begin
            started     = 1'b1;
            total_acc   = init_v;
            saved_total = init_v;
            save_ms     = now;
            tick_ms     = now;
        end

        if (!present) begin
            // missing input: total held, only the reset level is tracked
            res.total    = total_acc[TOT_W-1:0];
            res.qual     = QUAL_FAULT;
            res.status   = STAT_MISSING;
            res.save_req = 1'b0;
            prev_rst     = rst_lvl;
        end else begin
            scale_v = $signed(cfg_scale);
            if (scale_v == 0) scale_v = 65536;
            smag = (scale_v < 0) ? -scale_v : scale_v;
            if (!have_baseline) begin
                have_baseline = 1'b1;
                prev_sample   = sample;
                tick_ms       = now;
            end
            val_v = $signed(sample);

            if (rise) begin
                total_acc = init_v;
            end else if (cfg_mode <= MODE_ABS_DELTA) begin
                prev_v = $signed(prev_sample);
                diff   = val_v - prev_v;
                if (cfg_mode == MODE_ABS_DELTA) begin
                    if (diff < 0) diff = -diff;
                end else if (diff < 0) begin
                    diff = 0;
                end
                if (diff != 0) begin
                    dmag      = diff;
                    num       = {64'd0, dmag} * {64'd0, smag};
                    inc       = round_div(num, 64'd65536);
                    total_acc = clamp_add(total_acc, inc, scale_v < 0);
                end
            end else begin
                unit_ms = (cfg_mode == MODE_RATE_SEC)  ? MS_PER_SEC :
                          (cfg_mode == MODE_RATE_HOUR) ? MS_PER_HOUR : MS_PER_MIN;
                elapsed = (now >= tick_ms) ? now - tick_ms : '0;
                if (elapsed != 0 && val_v != 0) begin
                    vmag      = (val_v < 0) ? -val_v : val_v;
                    num       = {64'd0, vmag} * {64'd0, smag} * {96'd0, elapsed};
                    inc       = round_div(num, unit_ms << 16);
                    total_acc = clamp_add(total_acc, inc, (val_v < 0) != (scale_v < 0));
                end
            end

            persist = 1'b0;
            if (cfg_retain) begin
                sd       = (cfg_save_delta != 0) ? {17'd0, cfg_save_delta} : 64'd65536;
                period   = (cfg_period != 0) ? cfg_period : PERIOD_DFLT;
                gap      = total_acc - saved_total;
                if (gap < 0) gap = -gap;
                by_delta = gap >= sd;
                by_time  = (now >= save_ms) && ((now - save_ms) >= period);
                persist  = rise || by_delta || by_time;
            end
            store_ok = 1'b1;
            if (persist) begin
                store_ok = ready;
                if (ready) begin
                    saved_total = total_acc;
                    save_ms     = now;
                end
            end

            res.status = rise ? STAT_RESET : STAT_OK;
            if (persist)
                res.status = !store_ok ? STAT_SAVE_FAIL : (rise ? STAT_RESET_SAVED : STAT_SAVED);
            res.total    = total_acc[TOT_W-1:0];
            res.qual     = (qual == QUAL_UNINIT) ? QUAL_GOOD : qual;
            res.save_req = persist;

            prev_sample = sample;
            tick_ms     = now;
            prev_rst    = rst_lvl;
        end
        expected_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_tick_result got;
        t_tick_result want;
        if (!i_rst_n) begin
            cfg_mode       = MODE_DELTA;
            cfg_scale      = SCALE_ONE;
            cfg_init       = '0;
            cfg_retain     = 1'b0;
            cfg_save_delta = SD_DFLT;
            cfg_period     = PERIOD_DFLT;
            total_acc      = 0;
            saved_total    = 0;
            prev_sample    = '0;
            tick_ms        = '0;
            save_ms        = '0;
            prev_rst       = 1'b0;
            have_baseline  = 1'b0;
            started        = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE:    cfg_mode       = i_cfg_data[MODE_W-1:0];
                    REG_SCALE:   cfg_scale      = i_cfg_data[SCALE_W-1:0];
                    REG_INIT:    cfg_init       = i_cfg_data[TOT_W-1:0];
                    REG_RETAIN:  cfg_retain     = i_cfg_data[0];
                    REG_SAVE_DL: cfg_save_delta = i_cfg_data[SD_W-1:0];
                    REG_PERIOD:  cfg_period     = i_cfg_data[NOW_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                integrate_tick(i_s_tdata[31:0], i_s_tuser[0], i_s_tdata[63:32],
                               i_s_tuser[2:1], i_s_tdata[64], i_s_tdata[65]);
            if (i_m_tvalid && i_m_tready) begin
                got.total    = i_m_tdata[47:0];
                got.save_req = i_m_tdata[48];
                got.qual     = i_m_tuser[1:0];
                got.status   = i_m_tuser[4:2];
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result %0d arrived with nothing pending", $time,
                                 results_seen);
                end else begin
                    want = expected_q.pop_front();
                    if (got.total !== want.total || got.save_req !== want.save_req ||
                        got.qual !== want.qual || got.status !== want.status) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: result %0d total %h/%h save %b/%b qual %0d/%0d %s %0d/%0d",
                                     $time, results_seen, want.total, got.total,
                                     want.save_req, got.save_req, want.qual, got.qual,
                                     "status", want.status, got.status);
                    end
                end
                results_seen++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Top of the flow totalizer simulation: clock, reset, tick stimulus and register phases.
// Depends on ft_pkg, flow_totalizer_top and ft_tick_checker (which does all comparing).
module testbench;
    import ft_pkg::*;

    // Slowest honest run: ~1220 ticks plus sender gaps, receiver stalls, one hold-off
    // and 87 register writes with drains; the cap below sits far above that.
    localparam int CYCLE_LIMIT = 500000;

    // codes the package leaves unnamed
    localparam logic [QUAL_W-1:0]    QUAL_BAD      = 2'd2;
    localparam logic [MODE_W-1:0]    MODE_SPARE    = 3'd7;  // decoded as per-minute rate
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [71:0]           i_s_tdata   = '0;
    logic [2:0]            i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [55:0]           o_m_tdata;
    logic [4:0]            o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   items_sent  = 0;
    int   cycle_count = 0;
    logic calm        = 1'b0;   // no random idling on either side while set
    logic hold_off    = 1'b0;   // receiver fully stalled while set

    // running tick content for the random part
    logic [NOW_W-1:0] tick_now    = '0;
    logic [VAL_W-1:0] tick_sample = '0;
    logic             tick_rst    = 1'b0;

    always #5 i_clk = ~i_clk;

    flow_totalizer_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ft_tick_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result side: ~8% random stalls, none while calm, solid stall during the hold-off.
    always @(posedge i_clk) begin
        i_m_tready <= hold_off ? 1'b0 : (calm || $urandom_range(0, 99) >= 8);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Long receiver hold-off mid-run: sender keeps offering ticks, so the output register
    // fills, the next tick is taken and then the input side has to stall.
    initial begin
        wait (items_sent >= 700);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Offer one tick, with an optional random gap in front; returns at the accepting edge.
    // tvalid stays high into the next call unless that call idles first.
    task automatic send_tick(input logic [NOW_W-1:0] now, input logic present,
                             input logic [VAL_W-1:0] sample, input logic [QUAL_W-1:0] qual,
                             input logic rst_lvl, input logic ready);
        while (!calm && $urandom_range(0, 99) < 8) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, ready, rst_lvl, sample, now};
        i_s_tuser  <= {qual, present};
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // Stop offering and wait until every queued result has come back. The pending count
    // is registered in the checker, so it is only trusted once it has caught up.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Flow-like ticks: mostly steady time and small sample moves, with clock jumps,
    // clock going backwards, extreme samples, missing samples and reset pulses mixed in.
    task automatic random_ticks(input int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      tick_now = tick_now + $urandom_range(0, 1500);
            else if (pick < 80) tick_now = tick_now + $urandom_range(0, 300000);
            else if (pick < 86) tick_now = tick_now - $urandom_range(1, 5000);
            else if (pick < 92) tick_now = $urandom;
            // otherwise same timestamp again: zero elapsed time

            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                tick_sample = tick_sample + 32'($urandom_range(0, 2097152)) - 32'd1048576;
            end else if (pick < 85) begin
                tick_sample = $urandom;
            end else begin
                case ($urandom_range(0, 4))
                    0:       tick_sample = 32'h0000_0000;
                    1:       tick_sample = 32'h7FFF_FFFF;
                    2:       tick_sample = 32'h8000_0000;
                    3:       tick_sample = 32'h0000_0001;
                    default: tick_sample = 32'hFFFF_FFFF;
                endcase
            end

            // reset level: rare rise, then held for a few ticks
            tick_rst = $urandom_range(0, 99) < (tick_rst ? 50 : 5);
            send_tick(tick_now, $urandom_range(0, 99) >= 8, tick_sample,
                      QUAL_W'($urandom_range(0, 3)), tick_rst, $urandom_range(0, 99) < 85);
        end
    endtask

    initial begin
        logic [63:0]        wide;
        logic [SCALE_W-1:0] scale_pick;
        logic [TOT_W-1:0]   init_pick;
        logic [SD_W-1:0]    sd_pick;
        logic [NOW_W-1:0]   period_pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // positive-delta mode, default gain, retention on
        write_reg(REG_RETAIN, 48'd1);
        send_tick(32'd1000, 1'b1, 32'h0000_0000, QUAL_UNINIT, 1'b0, 1'b1); // baseline only
        send_tick(32'd1010, 1'b1, 32'h7FFF_FFFF, QUAL_GOOD, 1'b0, 1'b1);   // big rise, save
        send_tick(32'd1020, 1'b1, 32'h8000_0000, QUAL_BAD, 1'b0, 1'b0);    // drop counts zero
        send_tick(32'd1030, 1'b0, 32'h1234_5678, QUAL_FAULT, 1'b0, 1'b1);  // missing sample
        send_tick(32'd1040, 1'b1, 32'h0001_0000, QUAL_FAULT, 1'b1, 1'b1);  // reset edge, saved
        send_tick(32'd1050, 1'b1, 32'h0003_0000, QUAL_GOOD, 1'b1, 1'b0);   // level held, save fails
        send_tick(32'd0, 1'b1, 32'h0002_8000, QUAL_GOOD, 1'b0, 1'b1);      // clock backwards
        send_tick(32'hFFFF_FFFF, 1'b1, 32'hFFFF_0000, QUAL_UNINIT, 1'b0, 1'b1); // period ran out

        // absolute delta with the most negative gain
        write_reg(REG_MODE, {45'd0, MODE_ABS_DELTA});
        write_reg(REG_SCALE, 48'h0000_8000_0000);
        send_tick(32'hFFFF_FFFF, 1'b1, 32'h8000_0000, QUAL_GOOD, 1'b0, 1'b1);
        // reset rising while the sample is missing: the edge is used up there
        send_tick(32'hFFFF_FFFF, 1'b0, 32'h0000_0000, QUAL_GOOD, 1'b1, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, QUAL_GOOD, 1'b1, 1'b1);

        // per-second rate, zero gain taken as one, shortest save period
        write_reg(REG_MODE, {45'd0, MODE_RATE_SEC});
        write_reg(REG_SCALE, 48'd0);
        write_reg(REG_PERIOD, 48'd1);
        send_tick(32'd1000, 1'b1, 32'h0001_0000, QUAL_GOOD, 1'b0, 1'b1);   // clock wrapped back
        send_tick(32'd2000, 1'b1, 32'h7FFF_FFFF, QUAL_GOOD, 1'b0, 1'b1);
        send_tick(32'd3000, 1'b1, 32'h8000_0000, QUAL_BAD, 1'b0, 1'b0);

        // per-hour rate, largest gain, start value at the top: saturate upward
        write_reg(REG_MODE, {45'd0, MODE_RATE_HOUR});
        write_reg(REG_SCALE, 48'h0000_7FFF_FFFF);
        write_reg(REG_INIT, TOT_MAX);
        send_tick(32'h8000_0000, 1'b1, 32'h7FFF_FFFF, QUAL_GOOD, 1'b0, 1'b1);
        send_tick(32'h8000_0010, 1'b1, 32'h7FFF_FFFF, QUAL_GOOD, 1'b1, 1'b1);
        send_tick(32'hC000_0000, 1'b1, 32'h7FFF_FFFF, QUAL_GOOD, 1'b0, 1'b1);

        // spare mode code, start value at the bottom, negative sample and gain: total climbs
        write_reg(REG_MODE, {45'd0, MODE_SPARE});
        write_reg(REG_INIT, TOT_MIN);
        write_reg(REG_SCALE, 48'h0000_8000_0000);
        send_tick(32'hC000_0100, 1'b1, 32'hFFFF_FFFF, QUAL_UNINIT, 1'b1, 1'b1);
        send_tick(32'hFFFF_0000, 1'b1, 32'hFFFF_FFFF, QUAL_GOOD, 1'b0, 1'b0);

        // unused indexes must leave everything alone
        wide = {$urandom, $urandom};
        write_reg(REG_UNUSED_LO, wide[47:0]);
        wide = {$urandom, $urandom};
        write_reg(REG_UNUSED_HI, wide[47:0]);
        write_reg(REG_MODE, {45'd0, MODE_RATE_MIN});
        send_tick(32'hFFFF_FFF0, 1'b1, 32'h0010_0000, QUAL_GOOD, 1'b0, 1'b1);
        tick_now = 32'hFFFF_FFF0;

        // ---- random phases ----
        for (int phase = 0; phase < 12; phase++) begin
            calm <= (phase == 4);

            case ($urandom_range(0, 5))
                0:       scale_pick = '0;
                1:       scale_pick = SCALE_ONE;
                2:       scale_pick = 32'h8000_0000;
                3:       scale_pick = 32'h7FFF_FFFF;
                4:       scale_pick = 32'($urandom_range(0, 262144)) - 32'd131072;
                default: scale_pick = $urandom;
            endcase
            wide = {$urandom, $urandom};
            case ($urandom_range(0, 4))
                0:       init_pick = '0;
                1:       init_pick = TOT_MIN;
                2:       init_pick = TOT_MAX;
                3:       init_pick = 48'($urandom_range(0, 2000000)) - 48'd1000000;
                default: init_pick = wide[47:0];
            endcase
            // save thresholds: top, bottom and zero once each, then random
            wide = {$urandom, $urandom};
            if (phase == 0) begin
                sd_pick     = '1;
                period_pick = '1;
            end else if (phase == 1) begin
                sd_pick     = 47'd1;
                period_pick = 32'd1;
            end else if (phase == 2) begin
                sd_pick     = '0;
                period_pick = '0;
            end else begin
                sd_pick     = $urandom_range(0, 1) ? SD_W'($urandom_range(1, 4194304)) : wide[46:0];
                period_pick = $urandom_range(0, 1) ? NOW_W'($urandom_range(1, 20000)) : $urandom;
            end

            // upper data bits carry junk to show the register widths are honored
            write_reg(REG_MODE, {45'($urandom), 3'(phase % 8)});
            write_reg(REG_SCALE, {16'($urandom), scale_pick});
            write_reg(REG_INIT, init_pick);
            write_reg(REG_RETAIN, {47'($urandom), 1'(phase % 4 != 3)});
            write_reg(REG_SAVE_DL, {1'($urandom), sd_pick});
            write_reg(REG_PERIOD, {16'($urandom), period_pick});

            random_ticks(100);
        end
        calm <= 1'b0;

        drain_results();
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ft_pkg.sv
hdl/ft_ctrl.sv
hdl/ft_dpath.sv
hdl/flow_totalizer_top.sv
sim/ft_tick_checker.sv
sim/testbench.sv
